// ===== rtl/bpq_pkg.sv =====
`default_nettype none

package bpq_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation codes carried by in_kind
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // insert that fits: cells at or behind the slot shift toward the tail
    logic del;  // delete from a non-empty queue: every cell takes its right neighbor
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/bpq_cell.sv =====
`default_nettype none

module bpq_cell #(
  parameter int PRIO_BITS    = 8,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire                     clk,
  input  bpq_pkg::cell_ctrl_t     ctrl,
  input  wire                     occ,
  input  wire  [PRIO_BITS-1:0]    new_prio,
  input  wire  [PAYLOAD_BITS-1:0] new_payload,
  input  wire                     left_stay,
  input  wire  [PRIO_BITS-1:0]    left_prio,
  input  wire  [PAYLOAD_BITS-1:0] left_payload,
  input  wire  [PRIO_BITS-1:0]    right_prio,
  input  wire  [PAYLOAD_BITS-1:0] right_payload,
  output logic                    stay,
  output logic [PRIO_BITS-1:0]    prio,
  output logic [PAYLOAD_BITS-1:0] payload
);
  import bpq_pkg::*;

  logic [PRIO_BITS-1:0]    prio_r,    prio_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;

  // Entry keeps its place when it ranks at or above the new word (FIFO on ties)
  assign stay = occ && (prio_r >= new_prio);

  // Next contents: hold, take the new word, take the left word, or take the right word
  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (ctrl.ins) begin
      if (!stay) begin
        if (left_stay) begin
          prio_nxt    = new_prio;
          payload_nxt = new_payload;
        end else begin
          prio_nxt    = left_prio;
          payload_nxt = left_payload;
        end
      end
    end else if (ctrl.del) begin
      prio_nxt    = right_prio;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

`default_nettype wire

// ===== rtl/bounded_priority_queue_core.sv =====
`default_nettype none
// Sorted max-first queue built as a row of DEPTH cells, cell 0 holding the next word out.
// Each result word is registered in the output register in the cycle after its input is accepted.
// Throughput: one insert or delete per cycle while in_stall is low; the limit is the priority compare
//   broadcast to all cells and the shift into each cell's neighbor.
// Reset: synchronous, active low; clears the entry count and the output valid. Cell contents
//   are not cleared; only cells below the count are ever read.

module bounded_priority_queue_core #(
  parameter int DEPTH        = 16,
  parameter int PRIO_BITS    = 8,
  parameter int PAYLOAD_BITS = 32,
  localparam int CNT_W       = $clog2(DEPTH + 1)
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // input channel
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     in_kind,
  input  wire  [PRIO_BITS-1:0]    in_priority_req,
  input  wire  [PAYLOAD_BITS-1:0] in_payload,
  // result channel
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [PRIO_BITS-1:0]    out_priority,
  output logic [PAYLOAD_BITS-1:0] out_payload,
  output bpq_pkg::status_t        out_status,
  output logic [CNT_W-1:0]        out_count
);
  import bpq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PRIO_BITS-1:0]    out_priority_r, out_priority_nxt;
  logic [PAYLOAD_BITS-1:0] out_payload_r, out_payload_nxt;
  status_t                 out_status_r, out_status_nxt;

  logic                    accept;
  logic                    full, empty;
  cell_ctrl_t              ctrl;

  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        stay;
  logic [PRIO_BITS-1:0]    cell_prio    [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];

  // Handshake: the output register frees up when empty or being taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  // Command broadcast to the row
  always_comb begin
    ctrl.ins = accept && (in_kind == KIND_INSERT) && !full;
    ctrl.del = accept && (in_kind == KIND_DELETE) && !empty;
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    l_stay;
    logic [PRIO_BITS-1:0]    l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0] l_payload, r_payload;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign l_stay    = 1'b1;
      assign l_prio    = in_priority_req;
      assign l_payload = in_payload;
    end else begin : g_body
      assign l_stay    = stay[i-1];
      assign l_prio    = cell_prio[i-1];
      assign l_payload = cell_payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio    = cell_prio[i];
      assign r_payload = cell_payload[i];
    end else begin : g_mid
      assign r_prio    = cell_prio[i+1];
      assign r_payload = cell_payload[i+1];
    end

    bpq_cell #(
      .PRIO_BITS    (PRIO_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occ           (occ[i]),
      .new_prio      (in_priority_req),
      .new_payload   (in_payload),
      .left_stay     (l_stay),
      .left_prio     (l_prio),
      .left_payload  (l_payload),
      .right_prio    (r_prio),
      .right_payload (r_payload),
      .stay          (stay[i]),
      .prio          (cell_prio[i]),
      .payload       (cell_payload[i])
    );
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.del) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Result word
  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    out_priority_nxt = out_priority_r;
    out_payload_nxt  = out_payload_r;
    out_status_nxt   = out_status_r;
    if (accept) begin
      out_valid_nxt    = 1'b1;
      out_priority_nxt = '0;
      out_payload_nxt  = '0;
      out_status_nxt   = ST_OK;
      if (in_kind == KIND_INSERT) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          out_priority_nxt = cell_prio[0];
          out_payload_nxt  = cell_payload[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register, no reset
  always_ff @(posedge clk) begin
    out_priority_r <= out_priority_nxt;
    out_payload_r  <= out_payload_nxt;
    out_status_r   <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_priority = out_priority_r;
  assign out_payload  = out_payload_r;
  assign out_status   = out_status_r;
  assign out_count    = count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_INSERT) && !full |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_EMPTY) |-> (count_r == '0) && (out_priority_r == '0))
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> count_r == FULL_CNT)
    else $error("full status with room left");

endmodule

`default_nettype wire
